FILE: hw/rtl/rqzg_pkg.sv
// ----------------------------------------------------------------------------
// rqzg_pkg
// Shared widths, codes, pipeline structs and the CORDIC arctangent table for
// the rotated quadrant zone generator.
// ----------------------------------------------------------------------------
package rqzg_pkg;

  // grid and iteration limits
  localparam int unsigned MAX_GRID     = 4096;
  localparam int unsigned CORDIC_STEPS = 16;
  localparam int unsigned ATAN_ENTRIES = 24;
  localparam int unsigned STEP_W       = $clog2(ATAN_ENTRIES);

  // field widths
  localparam int unsigned GRID_W  = 13;
  localparam int unsigned CELL_W  = 16;
  localparam int unsigned IDX_W   = 12;
  localparam int unsigned HEAD_W  = 15;
  localparam int unsigned COORD_W = 32;
  localparam int unsigned TRIG_W  = 32;
  localparam int unsigned Z_W     = 31;
  localparam int unsigned LEN_W   = 28;
  localparam int unsigned PROD_W  = LEN_W + 1 + TRIG_W;
  localparam int unsigned EXT_W   = 38;
  localparam int unsigned SUM_W   = 40;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  // angle and fixed point constants
  localparam int unsigned FULL_TURN    = 23040;
  localparam int unsigned QUARTER_TURN = 5760;
  localparam int unsigned CORDIC_GAIN  = 652032874;
  localparam int unsigned ROUND_BIAS   = 2 ** 21;
  localparam int unsigned FRAC_SHIFT   = 22;

  // register reset values
  localparam int unsigned GRID_ROWS_RST = 16;
  localparam int unsigned GRID_COLS_RST = 16;
  localparam int unsigned CELL_SIZE_RST = 256;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GRID_ROWS = 2'd0,
    REG_GRID_COLS = 2'd1,
    REG_CELL_SIZE = 2'd2
  } cfg_reg_t;

  // quadrant of the reduced heading
  typedef enum logic [1:0] {
    QUAD_0 = 2'd0,
    QUAD_1 = 2'd1,
    QUAD_2 = 2'd2,
    QUAD_3 = 2'd3
  } quad_t;

  // last zone number of an item
  localparam logic [1:0] ZONE_LAST = 2'd3;

  // data carried along the rotation chain
  typedef struct packed {
    logic signed [TRIG_W-1:0]  x;
    logic signed [TRIG_W-1:0]  y;
    logic signed [Z_W-1:0]     z;
    quad_t                     quad;
    logic signed [COORD_W-1:0] cx;
    logic signed [COORD_W-1:0] cy;
  } cordic_t;

  // centre plus scaled half vectors
  typedef struct packed {
    logic signed [COORD_W-1:0] cx;
    logic signed [COORD_W-1:0] cy;
    logic signed [EXT_W-1:0]   hx;
    logic signed [EXT_W-1:0]   hy;
    logic signed [EXT_W-1:0]   wx;
    logic signed [EXT_W-1:0]   wy;
  } geom_t;

  // arctangent of 2^-i in units of 2^-22 degree
  function automatic logic signed [Z_W-1:0] atan_of(input int unsigned i);
    case (i)
      0:       return 31'sd188743680;
      1:       return 31'sd111421900;
      2:       return 31'sd58872272;
      3:       return 31'sd29884485;
      4:       return 31'sd15000234;
      5:       return 31'sd7507429;
      6:       return 31'sd3754631;
      7:       return 31'sd1877430;
      8:       return 31'sd938729;
      9:       return 31'sd469366;
      10:      return 31'sd234683;
      11:      return 31'sd117342;
      12:      return 31'sd58671;
      13:      return 31'sd29335;
      14:      return 31'sd14668;
      15:      return 31'sd7334;
      16:      return 31'sd3667;
      17:      return 31'sd1833;
      18:      return 31'sd917;
      19:      return 31'sd458;
      20:      return 31'sd229;
      21:      return 31'sd115;
      22:      return 31'sd57;
      23:      return 31'sd29;
      default: return '0;
    endcase
  endfunction

endpackage

FILE: hw/rtl/rqzg_if.sv
// ----------------------------------------------------------------------------
// rqzg_if
// Valid/ready channel interfaces for the input beats and the zone beats.
// ----------------------------------------------------------------------------
interface rqzg_in_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [rqzg_pkg::COORD_W-1:0]   centre_x;
  logic signed [rqzg_pkg::COORD_W-1:0]   centre_y;
  logic        [rqzg_pkg::HEAD_W-1:0]    heading;

  modport source (output valid, output centre_x, output centre_y, output heading,
                  input ready);
  modport sink   (input valid, input centre_x, input centre_y, input heading,
                  output ready);
endinterface

interface rqzg_out_if;
  logic                                  valid;
  logic                                  ready;
  logic        [1:0]                     zone;
  logic        [rqzg_pkg::IDX_W-1:0]     row_first;
  logic        [rqzg_pkg::IDX_W-1:0]     col_first;
  logic        [rqzg_pkg::IDX_W-1:0]     row_last;
  logic        [rqzg_pkg::IDX_W-1:0]     col_last;
  logic signed [rqzg_pkg::COORD_W-1:0]   corner_a_x;
  logic signed [rqzg_pkg::COORD_W-1:0]   corner_a_y;
  logic signed [rqzg_pkg::COORD_W-1:0]   corner_b_x;
  logic signed [rqzg_pkg::COORD_W-1:0]   corner_b_y;
  logic signed [rqzg_pkg::COORD_W-1:0]   corner_c_x;
  logic signed [rqzg_pkg::COORD_W-1:0]   corner_c_y;
  logic                                  final_zone;

  modport source (output valid, output zone, output row_first, output col_first,
                  output row_last, output col_last, output corner_a_x,
                  output corner_a_y, output corner_b_x, output corner_b_y,
                  output corner_c_x, output corner_c_y, output final_zone,
                  input ready);
  modport sink   (input valid, input zone, input row_first, input col_first,
                  input row_last, input col_last, input corner_a_x,
                  input corner_a_y, input corner_b_x, input corner_b_y,
                  input corner_c_x, input corner_c_y, input final_zone,
                  output ready);
endinterface

FILE: hw/rtl/rqzg_cordic_cell.sv
// ----------------------------------------------------------------------------
// rqzg_cordic_cell
// One rotation-mode CORDIC iteration, registered, passing its vector, angle
// residue and the item's side data on to the next cell.
// ----------------------------------------------------------------------------
module rqzg_cordic_cell (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                en,
  input  logic [rqzg_pkg::STEP_W-1:0]         step,
  input  logic signed [rqzg_pkg::Z_W-1:0]     atan,
  input  logic                                d_vld,
  input  rqzg_pkg::cordic_t                   d,
  output logic                                q_vld,
  output rqzg_pkg::cordic_t                   q
);

  logic                                vld_r;
  rqzg_pkg::cordic_t                   q_r;
  rqzg_pkg::cordic_t                   q_nxt;
  logic signed [rqzg_pkg::TRIG_W-1:0]  dx;
  logic signed [rqzg_pkg::TRIG_W-1:0]  dy;

  // micro-rotation towards zero residue
  always_comb begin
    dx    = d.y >>> step;
    dy    = d.x >>> step;
    q_nxt = d;
    if (!d.z[rqzg_pkg::Z_W-1]) begin
      q_nxt.x = d.x - dx;
      q_nxt.y = d.y + dy;
      q_nxt.z = d.z - atan;
    end else begin
      q_nxt.x = d.x + dx;
      q_nxt.y = d.y - dy;
      q_nxt.z = d.z + atan;
    end
  end

  // beat valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= d_vld;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (en) begin
      q_r <= q_nxt;
    end
  end

  assign q_vld = vld_r;
  assign q     = q_r;

endmodule

FILE: hw/rtl/rqzg_scale.sv
// ----------------------------------------------------------------------------
// rqzg_scale
// Quadrant fold of sine and cosine, then the four length-by-trig products and
// their rounding to Q16.16, over three registered stages.
// ----------------------------------------------------------------------------
module rqzg_scale (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               en,
  input  logic [rqzg_pkg::LEN_W-1:0]         h_len,
  input  logic [rqzg_pkg::LEN_W-1:0]         w_len,
  input  logic                               d_vld,
  input  rqzg_pkg::cordic_t                  d,
  output logic                               q_vld,
  output rqzg_pkg::geom_t                    q
);

  logic                                 vld_a_r;
  logic                                 vld_b_r;
  logic                                 vld_c_r;
  logic signed [rqzg_pkg::TRIG_W-1:0]   sn_r, sn_nxt;
  logic signed [rqzg_pkg::TRIG_W-1:0]   cs_r, cs_nxt;
  logic signed [rqzg_pkg::COORD_W-1:0]  cx_a_r, cy_a_r;
  logic signed [rqzg_pkg::COORD_W-1:0]  cx_b_r, cy_b_r;
  logic signed [rqzg_pkg::PROD_W-1:0]   p_hs_r, p_hc_r, p_wc_r, p_ws_r;
  rqzg_pkg::geom_t                      geom_r;

  // round a Q38 product to Q16.16, half up
  function automatic logic signed [rqzg_pkg::EXT_W-1:0] rnd(
    input logic signed [rqzg_pkg::PROD_W-1:0] p
  );
    logic signed [rqzg_pkg::PROD_W-1:0] t;
    t = p + rqzg_pkg::PROD_W'(rqzg_pkg::ROUND_BIAS);
    return rqzg_pkg::EXT_W'(t >>> rqzg_pkg::FRAC_SHIFT);
  endfunction

  // fold the first-quadrant result into the full turn
  always_comb begin
    case (d.quad)
      rqzg_pkg::QUAD_0: begin
        sn_nxt = d.y;
        cs_nxt = d.x;
      end
      rqzg_pkg::QUAD_1: begin
        sn_nxt = d.x;
        cs_nxt = -d.y;
      end
      rqzg_pkg::QUAD_2: begin
        sn_nxt = -d.y;
        cs_nxt = -d.x;
      end
      rqzg_pkg::QUAD_3: begin
        sn_nxt = -d.x;
        cs_nxt = d.y;
      end
      default: begin
        sn_nxt = d.y;
        cs_nxt = d.x;
      end
    endcase
  end

  // stage valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_a_r <= 1'b0;
      vld_b_r <= 1'b0;
      vld_c_r <= 1'b0;
    end else if (en) begin
      vld_a_r <= d_vld;
      vld_b_r <= vld_a_r;
      vld_c_r <= vld_b_r;
    end
  end

  // fold, multiply, round
  always_ff @(posedge clk) begin
    if (en) begin
      sn_r      <= sn_nxt;
      cs_r      <= cs_nxt;
      cx_a_r    <= d.cx;
      cy_a_r    <= d.cy;
      p_hs_r    <= $signed({1'b0, h_len}) * sn_r;
      p_hc_r    <= $signed({1'b0, h_len}) * cs_r;
      p_wc_r    <= $signed({1'b0, w_len}) * cs_r;
      p_ws_r    <= $signed({1'b0, w_len}) * sn_r;
      cx_b_r    <= cx_a_r;
      cy_b_r    <= cy_a_r;
      geom_r.cx <= cx_b_r;
      geom_r.cy <= cy_b_r;
      geom_r.hx <= rnd(p_hs_r);
      geom_r.hy <= rnd(p_hc_r);
      geom_r.wx <= rnd(p_wc_r);
      geom_r.wy <= -rnd(p_ws_r);
    end
  end

  assign q_vld = vld_c_r;
  assign q     = geom_r;

endmodule

FILE: hw/rtl/rqzg_emit.sv
// ----------------------------------------------------------------------------
// rqzg_emit
// Holds one item's geometry and sends its four zone beats in order, taking
// the next item in the cycle its last beat goes out.
// ----------------------------------------------------------------------------
module rqzg_emit (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic [rqzg_pkg::GRID_W-1:0]        rows,
  input  logic [rqzg_pkg::GRID_W-1:0]        cols,
  input  logic                               d_vld,
  input  rqzg_pkg::geom_t                    d,
  output logic                               load_ok,
  rqzg_out_if.source                         out_ch
);

  typedef enum logic [1:0] {
    COEF_ZERO  = 2'd0,
    COEF_PLUS  = 2'd1,
    COEF_MINUS = 2'd2
  } coef_t;

  logic                                busy_r, busy_nxt;
  logic [1:0]                          zone_r, zone_nxt;
  rqzg_pkg::geom_t                     geom_r;
  logic                                last_beat;
  logic                                load;
  coef_t                               ha, wa, hb, wb, hc, wc;
  logic [rqzg_pkg::GRID_W-1:0]         rows_lo, cols_lo;

  // signed multiple of a half vector component
  function automatic logic signed [rqzg_pkg::EXT_W-1:0] apply(
    input coef_t                             c,
    input logic signed [rqzg_pkg::EXT_W-1:0] v
  );
    case (c)
      COEF_PLUS:  return v;
      COEF_MINUS: return -v;
      default:    return '0;
    endcase
  endfunction

  // centre plus two terms, saturated to 32 bits
  function automatic logic signed [rqzg_pkg::COORD_W-1:0] corner(
    input logic signed [rqzg_pkg::COORD_W-1:0] c,
    input logic signed [rqzg_pkg::EXT_W-1:0]   th,
    input logic signed [rqzg_pkg::EXT_W-1:0]   tw
  );
    logic signed [rqzg_pkg::SUM_W-1:0] s;
    s = rqzg_pkg::SUM_W'(c) + rqzg_pkg::SUM_W'(th) + rqzg_pkg::SUM_W'(tw);
    if (s > 40'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (s < -40'sd2147483648) begin
      return 32'sh80000000;
    end else begin
      return s[rqzg_pkg::COORD_W-1:0];
    end
  endfunction

  // handshake and zone counter
  always_comb begin
    last_beat = busy_r && out_ch.ready && (zone_r == rqzg_pkg::ZONE_LAST);
    load_ok   = !busy_r || last_beat;
    load      = load_ok && d_vld;
    busy_nxt  = busy_r;
    zone_nxt  = zone_r;
    if (load) begin
      busy_nxt = 1'b1;
      zone_nxt = '0;
    end else if (last_beat) begin
      busy_nxt = 1'b0;
    end else if (busy_r && out_ch.ready) begin
      zone_nxt = zone_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      zone_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      zone_r <= zone_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      geom_r <= d;
    end
  end

  // corner recipes per zone
  always_comb begin
    case (zone_r)
      2'd0: begin
        ha = COEF_PLUS;  wa = COEF_PLUS;
        hb = COEF_PLUS;  wb = COEF_ZERO;
        hc = COEF_ZERO;  wc = COEF_PLUS;
      end
      2'd1: begin
        ha = COEF_ZERO;  wa = COEF_PLUS;
        hb = COEF_MINUS; wb = COEF_ZERO;
        hc = COEF_MINUS; wc = COEF_PLUS;
      end
      2'd2: begin
        ha = COEF_PLUS;  wa = COEF_ZERO;
        hb = COEF_PLUS;  wb = COEF_MINUS;
        hc = COEF_ZERO;  wc = COEF_MINUS;
      end
      default: begin
        ha = COEF_ZERO;  wa = COEF_MINUS;
        hb = COEF_MINUS; wb = COEF_MINUS;
        hc = COEF_MINUS; wc = COEF_ZERO;
      end
    endcase
  end

  // index ranges: near half holds the larger share
  assign rows_lo = rows - {1'b0, rows[rqzg_pkg::GRID_W-1:1]};
  assign cols_lo = cols - {1'b0, cols[rqzg_pkg::GRID_W-1:1]};

  assign out_ch.valid      = busy_r;
  assign out_ch.zone       = zone_r;
  assign out_ch.final_zone = (zone_r == rqzg_pkg::ZONE_LAST);
  assign out_ch.row_first  = zone_r[0] ? rows_lo[rqzg_pkg::IDX_W-1:0] : '0;
  assign out_ch.row_last   = zone_r[0] ? rqzg_pkg::IDX_W'(rows - 1'b1)
                                       : rqzg_pkg::IDX_W'(rows_lo - 1'b1);
  assign out_ch.col_first  = zone_r[1] ? cols_lo[rqzg_pkg::IDX_W-1:0] : '0;
  assign out_ch.col_last   = zone_r[1] ? rqzg_pkg::IDX_W'(cols - 1'b1)
                                       : rqzg_pkg::IDX_W'(cols_lo - 1'b1);

  // corners of this zone
  assign out_ch.corner_a_x = corner(geom_r.cx, apply(ha, geom_r.hx), apply(wa, geom_r.wx));
  assign out_ch.corner_a_y = corner(geom_r.cy, apply(ha, geom_r.hy), apply(wa, geom_r.wy));
  assign out_ch.corner_b_x = corner(geom_r.cx, apply(hb, geom_r.hx), apply(wb, geom_r.wx));
  assign out_ch.corner_b_y = corner(geom_r.cy, apply(hb, geom_r.hy), apply(wb, geom_r.wy));
  assign out_ch.corner_c_x = corner(geom_r.cx, apply(hc, geom_r.hx), apply(wc, geom_r.wx));
  assign out_ch.corner_c_y = corner(geom_r.cy, apply(hc, geom_r.hy), apply(wc, geom_r.wy));

endmodule

FILE: hw/rtl/rotated_quadrant_zone_generator.sv
// ----------------------------------------------------------------------------
// rotated_quadrant_zone_generator
// Top level: configuration registers, heading reduction, CORDIC cell chain,
// scaling stages and the zone beat emitter.
// ----------------------------------------------------------------------------
// Each input beat (centre, heading) produces four zone beats, zones 0 to 3,
// the last flagged by final_zone. The first zone beat appears after the input
// beat passes the reduction stage, which captures it at the accepting edge,
// then 16 CORDIC cells (one per iteration), three scaling stages and the
// emitter's holding register. The remaining three zone beats follow in
// consecutive cycles while out ready is high. Items stream through the chain
// back to back, but the single result port sends four beats per item, so the
// input takes one beat per four zone beats sent; the whole chain holds while a
// finished item waits at its end for the emitter. The user must write
// configuration only while no item is in flight; the block does not enforce it.
module rotated_quadrant_zone_generator (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [rqzg_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [rqzg_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  rqzg_in_if.sink                              in_ch,
  rqzg_out_if.source                           out_ch
);

  localparam int unsigned NCELL = rqzg_pkg::CORDIC_STEPS;

  logic [rqzg_pkg::GRID_W-1:0]    grid_rows_r;
  logic [rqzg_pkg::GRID_W-1:0]    grid_cols_r;
  logic [rqzg_pkg::CELL_W-1:0]    cell_size_r;
  logic [rqzg_pkg::GRID_W-1:0]    rows_cl, cols_cl;
  logic [rqzg_pkg::LEN_W-1:0]     h_len_r, w_len_r;

  logic                           en;
  logic                           load_ok;
  logic [rqzg_pkg::HEAD_W-1:0]    head_mod;
  logic [rqzg_pkg::HEAD_W-1:0]    head_rem;
  rqzg_pkg::quad_t                quad;
  rqzg_pkg::cordic_t              prep_nxt;
  logic                           prep_vld_r;
  rqzg_pkg::cordic_t              prep_r;

  logic                           chain_vld [NCELL+1];
  rqzg_pkg::cordic_t              chain_d   [NCELL+1];
  logic                           tail_vld;
  rqzg_pkg::geom_t                tail_d;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_rows_r <= rqzg_pkg::GRID_W'(rqzg_pkg::GRID_ROWS_RST);
      grid_cols_r <= rqzg_pkg::GRID_W'(rqzg_pkg::GRID_COLS_RST);
      cell_size_r <= rqzg_pkg::CELL_W'(rqzg_pkg::CELL_SIZE_RST);
    end else if (cfg_we) begin
      case (cfg_index)
        rqzg_pkg::REG_GRID_ROWS: grid_rows_r <= cfg_wdata[rqzg_pkg::GRID_W-1:0];
        rqzg_pkg::REG_GRID_COLS: grid_cols_r <= cfg_wdata[rqzg_pkg::GRID_W-1:0];
        rqzg_pkg::REG_CELL_SIZE: cell_size_r <= cfg_wdata[rqzg_pkg::CELL_W-1:0];
        default: ;
      endcase
    end
  end

  // grid sizes clamped to 1..MAX_GRID
  assign rows_cl = (grid_rows_r == '0) ? rqzg_pkg::GRID_W'(1) :
                   (32'(grid_rows_r) > rqzg_pkg::MAX_GRID) ?
                   rqzg_pkg::GRID_W'(rqzg_pkg::MAX_GRID) : grid_rows_r;
  assign cols_cl = (grid_cols_r == '0) ? rqzg_pkg::GRID_W'(1) :
                   (32'(grid_cols_r) > rqzg_pkg::MAX_GRID) ?
                   rqzg_pkg::GRID_W'(rqzg_pkg::MAX_GRID) : grid_cols_r;

  // half lengths in Q8.8
  always_ff @(posedge clk) begin
    h_len_r <= rqzg_pkg::LEN_W'(rows_cl[rqzg_pkg::GRID_W-1:1] * cell_size_r);
    w_len_r <= rqzg_pkg::LEN_W'(cols_cl[rqzg_pkg::GRID_W-1:1] * cell_size_r);
  end

  // whole chain advances together
  assign en          = !tail_vld || load_ok;
  assign in_ch.ready = en;

  // heading reduction to quadrant and remainder
  always_comb begin
    head_mod = (in_ch.heading >= rqzg_pkg::HEAD_W'(rqzg_pkg::FULL_TURN)) ?
               in_ch.heading - rqzg_pkg::HEAD_W'(rqzg_pkg::FULL_TURN) : in_ch.heading;
    if (head_mod >= rqzg_pkg::HEAD_W'(3 * rqzg_pkg::QUARTER_TURN)) begin
      quad     = rqzg_pkg::QUAD_3;
      head_rem = head_mod - rqzg_pkg::HEAD_W'(3 * rqzg_pkg::QUARTER_TURN);
    end else if (head_mod >= rqzg_pkg::HEAD_W'(2 * rqzg_pkg::QUARTER_TURN)) begin
      quad     = rqzg_pkg::QUAD_2;
      head_rem = head_mod - rqzg_pkg::HEAD_W'(2 * rqzg_pkg::QUARTER_TURN);
    end else if (head_mod >= rqzg_pkg::HEAD_W'(rqzg_pkg::QUARTER_TURN)) begin
      quad     = rqzg_pkg::QUAD_1;
      head_rem = head_mod - rqzg_pkg::HEAD_W'(rqzg_pkg::QUARTER_TURN);
    end else begin
      quad     = rqzg_pkg::QUAD_0;
      head_rem = head_mod;
    end
    prep_nxt.x    = rqzg_pkg::TRIG_W'(rqzg_pkg::CORDIC_GAIN);
    prep_nxt.y    = '0;
    prep_nxt.z    = $signed(rqzg_pkg::Z_W'({head_rem, 16'h0000}));
    prep_nxt.quad = quad;
    prep_nxt.cx   = in_ch.centre_x;
    prep_nxt.cy   = in_ch.centre_y;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prep_vld_r <= 1'b0;
    end else if (en) begin
      prep_vld_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prep_r <= prep_nxt;
    end
  end

  // CORDIC cell chain, one iteration per cell
  assign chain_vld[0] = prep_vld_r;
  assign chain_d[0]   = prep_r;

  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    rqzg_cordic_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .step  (rqzg_pkg::STEP_W'(i)),
      .atan  (rqzg_pkg::atan_of(i)),
      .d_vld (chain_vld[i]),
      .d     (chain_d[i]),
      .q_vld (chain_vld[i+1]),
      .q     (chain_d[i+1])
    );
  end

  // trig fold and scaling
  rqzg_scale u_scale (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .h_len (h_len_r),
    .w_len (w_len_r),
    .d_vld (chain_vld[NCELL]),
    .d     (chain_d[NCELL]),
    .q_vld (tail_vld),
    .q     (tail_d)
  );

  // zone beats
  rqzg_emit u_emit (
    .clk     (clk),
    .rst_n   (rst_n),
    .rows    (rows_cl),
    .cols    (cols_cl),
    .d_vld   (tail_vld),
    .d       (tail_d),
    .load_ok (load_ok),
    .out_ch  (out_ch)
  );

`ifndef NO_ASSERTIONS
  // zones of one item go out consecutively
  a_zone_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.ready && !out_ch.final_zone
    |=> out_ch.valid && (out_ch.zone == $past(out_ch.zone) + 2'd1))
    else $error("zone sequence broken");

  // a finished item waits at the chain end until the emitter takes it
  a_tail_hold: assert property (@(posedge clk) disable iff (!rst_n)
    tail_vld && !load_ok |=> tail_vld && $stable(tail_d))
    else $error("item lost at chain end");

  // an accepted input beat enters the chain
  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> prep_vld_r)
    else $error("accepted beat not captured");
`endif

endmodule
